// ===== rtl/scrm_pkg.sv =====
`default_nettype none
package scrm_pkg;

   // queue depth between the parts and on the result side
   localparam int QUEUE_DEPTH = 2;

   // configuration reset values
   localparam logic [7:0]  DEVICE_ADDR_RESET = 8'h60;
   localparam logic [15:0] DELAY_TICKS_RESET = 16'd1;

   // register indexes on the csr port
   localparam logic REG_DEVICE_ADDR = 1'b0;
   localparam logic REG_DELAY_TICKS = 1'b1;

   // command codes
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // transaction steps
   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_START,
      STEP_WBYTE,
      STEP_STOP,
      STEP_RBYTE,
      STEP_NACK
   } step_type;

   // segments per step
   localparam logic [4:0] SEGS_WBYTE = 5'd19;
   localparam logic [4:0] SEGS_RBYTE = 5'd17;
   localparam logic [4:0] SEGS_SHORT = 5'd3;

   // classified tick from the front part
   typedef struct packed {
      logic       start;
      logic       rd;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
      logic       sda;
   } item_type;

   // one result per tick
   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy;
      logic       done;
      logic [7:0] read_data;
      logic       ack_ok;
      logic       refused;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/scrm_fifo.sv =====
`default_nettype none
module scrm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/scrm_front.sv =====
`default_nettype none
module scrm_front
   import scrm_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [1:0] cmd,
   input  wire logic [7:0] reg_addr,
   input  wire logic [7:0] write_data,
   input  wire logic       sda_in,
   input  wire logic       pop,
   output item_type        item,
   output logic            empty
);

   item_type                   class_item;
   logic [$bits(item_type)-1:0] item_bits;

   // classify the command; code three counts as a plain tick
   always_comb begin
      class_item.start      = (cmd == CMD_WRITE) || (cmd == CMD_READ);
      class_item.rd         = (cmd == CMD_READ);
      class_item.reg_addr   = reg_addr;
      class_item.write_data = write_data;
      class_item.sda        = sda_in;
   end

   scrm_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (class_item),
      .full      (full),
      .pop       (pop),
      .pop_data  (item_bits),
      .empty     (empty)
   );

   assign item = item_type'(item_bits);

endmodule
`default_nettype wire

// ===== rtl/scrm_engine.sv =====
`default_nettype none
module scrm_engine
   import scrm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  device_addr,
   input  wire logic [15:0] delay_ticks,
   input  wire item_type    item,
   input  wire logic        item_empty,
   output logic             item_pop,
   input  wire logic        result_full,
   output logic             result_push,
   output result_type       result
);

   localparam logic [1:0] BYTE_REG     = 2'd1;
   localparam logic [1:0] BYTE_DATA    = 2'd2;
   localparam logic [1:0] BYTE_DEV_RD  = 2'd3;

   step_type    step_ff, step_in;
   logic [4:0]  phase_ff, phase_in;
   logic [1:0]  bit_count_ff, bit_count_in;
   logic [15:0] wait_ff, wait_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  read_value_ff, read_value_in;
   logic        ack_ff, ack_in;
   logic        is_read_ff, is_read_in;
   logic [7:0]  reg_latch_ff, reg_latch_in;
   logic [7:0]  data_latch_ff, data_latch_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in_lvl;
   logic        en_ff, en_in;
   logic        advance;

   // byte sent in slot idx
   function automatic logic [7:0] byte_for(input logic [1:0] idx, input logic [7:0] rl,
                                           input logic [7:0] dl, input logic [7:0] dev);
      logic [7:0] b;
      b = dev;
      if (idx == BYTE_REG) begin
         b = rl;
      end else if (idx == BYTE_DATA) begin
         b = dl;
      end else if (idx == BYTE_DEV_RD) begin
         b = dev | 8'h01;
      end
      return b;
   endfunction

   assign advance     = !item_empty && !result_full;
   assign item_pop    = advance;
   assign result_push = advance;

   // next state and result of one tick
   always_comb begin
      logic       apply;
      logic       done;
      logic       refd;
      logic [4:0] segs;

      step_in       = step_ff;
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      wait_in       = wait_ff;
      shift_in      = shift_ff;
      read_value_in = read_value_ff;
      ack_in        = ack_ff;
      is_read_in    = is_read_ff;
      reg_latch_in  = reg_latch_ff;
      data_latch_in = data_latch_ff;
      scl_in        = scl_ff;
      sda_in_lvl    = sda_ff;
      en_in         = en_ff;
      apply         = 1'b0;
      done          = 1'b0;
      refd          = 1'b0;
      segs          = SEGS_SHORT;

      if (step_ff == STEP_IDLE) begin
         // new command latches its operands
         if (item.start) begin
            reg_latch_in  = item.reg_addr;
            data_latch_in = item.write_data;
            is_read_in    = item.rd;
            if (!item.rd) begin
               ack_in = 1'b1;
            end
            bit_count_in = '0;
            phase_in     = '0;
            step_in      = STEP_START;
            apply        = 1'b1;
         end
      end else begin
         if (item.start) begin
            refd = 1'b1;
         end
         if (wait_ff != '0) begin
            wait_in = wait_ff - 16'd1;
         end else begin
            phase_in = phase_ff + 5'd1;
            if (step_ff == STEP_WBYTE) begin
               segs = SEGS_WBYTE;
            end else if (step_ff == STEP_RBYTE) begin
               segs = SEGS_RBYTE;
            end
            // step transition at the end of its segments
            if (phase_in >= segs) begin
               phase_in = '0;
               unique case (step_ff)
                  STEP_START: begin
                     step_in  = STEP_WBYTE;
                     shift_in = byte_for(bit_count_ff, reg_latch_ff, data_latch_ff,
                                         device_addr);
                  end
                  STEP_WBYTE: begin
                     if (!is_read_ff && (!ack_ff || bit_count_ff >= 2'd2)) begin
                        step_in = STEP_STOP;
                     end else if (is_read_ff && bit_count_ff == 2'd1) begin
                        step_in = STEP_STOP;
                     end else if (is_read_ff && bit_count_ff == 2'd3) begin
                        step_in = STEP_RBYTE;
                     end else begin
                        bit_count_in = bit_count_ff + 2'd1;
                        shift_in = byte_for(bit_count_in, reg_latch_ff, data_latch_ff,
                                            device_addr);
                     end
                  end
                  STEP_STOP: begin
                     if (is_read_ff && bit_count_ff == 2'd1) begin
                        bit_count_in = 2'd3;
                        step_in      = STEP_START;
                     end else begin
                        step_in = STEP_IDLE;
                        done    = 1'b1;
                     end
                  end
                  STEP_RBYTE: step_in = STEP_NACK;
                  STEP_NACK:  step_in = STEP_STOP;
                  default:    step_in = step_ff;
               endcase
            end
            if (step_in != STEP_IDLE) begin
               apply = 1'b1;
            end
         end
      end

      // pin actions of the segment that starts this tick
      if (apply) begin
         unique case (step_in)
            STEP_START: begin
               if (phase_in == 5'd0) begin
                  sda_in_lvl = 1'b1;
                  scl_in     = 1'b1;
               end else if (phase_in == 5'd1) begin
                  sda_in_lvl = 1'b0;
               end else begin
                  scl_in = 1'b0;
               end
            end
            STEP_WBYTE: begin
               if (phase_in < 5'd16) begin
                  if (!phase_in[0]) begin
                     scl_in     = 1'b0;
                     sda_in_lvl = shift_in[3'd7 - phase_in[3:1]];
                  end else begin
                     scl_in = 1'b1;
                  end
               end else if (phase_in == 5'd16) begin
                  scl_in = 1'b0;
                  en_in  = 1'b0;
               end else if (phase_in == 5'd17) begin
                  scl_in = 1'b1;
               end else begin
                  if (!is_read_in && item.sda) begin
                     ack_in = 1'b0;
                  end
                  scl_in = 1'b0;
                  en_in  = 1'b1;
               end
            end
            STEP_STOP: begin
               if (phase_in == 5'd0) begin
                  sda_in_lvl = 1'b0;
               end else if (phase_in == 5'd1) begin
                  scl_in = 1'b1;
               end else begin
                  sda_in_lvl = 1'b1;
               end
            end
            STEP_RBYTE: begin
               if (phase_in == 5'd0) begin
                  en_in    = 1'b0;
                  shift_in = '0;
               end else if (phase_in[0]) begin
                  scl_in   = 1'b1;
                  shift_in = {shift_in[6:0], item.sda};
               end else begin
                  scl_in = 1'b0;
                  if (phase_in == 5'd16) begin
                     en_in = 1'b1;
                  end
               end
            end
            STEP_NACK: begin
               if (phase_in == 5'd0) begin
                  read_value_in = shift_in;
                  sda_in_lvl    = 1'b1;
                  scl_in        = 1'b1;
               end else if (phase_in == 5'd1) begin
                  scl_in = 1'b0;
               end else begin
                  sda_in_lvl = 1'b0;
               end
            end
            default: begin
               scl_in = scl_ff;
            end
         endcase
         wait_in = (delay_ticks == '0) ? '0 : delay_ticks - 16'd1;
      end

      result.scl       = scl_in;
      result.sda_out   = sda_in_lvl;
      result.sda_drive = en_in;
      result.busy      = (step_in != STEP_IDLE);
      result.done      = done;
      result.read_data = read_value_in;
      result.ack_ok    = ack_in;
      result.refused   = refd;
   end

   // state registers, updated once per tick taken
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= STEP_IDLE;
         phase_ff      <= '0;
         bit_count_ff  <= '0;
         wait_ff       <= '0;
         shift_ff      <= '0;
         read_value_ff <= '0;
         ack_ff        <= 1'b0;
         is_read_ff    <= 1'b0;
         reg_latch_ff  <= '0;
         data_latch_ff <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         en_ff         <= 1'b1;
      end else if (advance) begin
         step_ff       <= step_in;
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         wait_ff       <= wait_in;
         shift_ff      <= shift_in;
         read_value_ff <= read_value_in;
         ack_ff        <= ack_in;
         is_read_ff    <= is_read_in;
         reg_latch_ff  <= reg_latch_in;
         data_latch_ff <= data_latch_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in_lvl;
         en_ff         <= en_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/sccb_register_master.sv =====
`default_nettype none
// SCCB three-phase register master. Each transfer on the req_ side is one tick of
// bit timing: a sampled SDA level plus an optional command (1 register write,
// 2 register read); each tick gives exactly one result on the rsp_ side with the
// pin levels, busy, done, read data, acknowledge status and a refused flag for a
// command that arrived while a transaction was running. One tick is taken every
// clock cycle while a tick is queued and the result queue has room; the engine
// registers its state once per tick, and QUEUE_DEPTH_P-entry queues on both sides
// let either side stall on its own; results are registered in the result queue.
// Every pin change is held for delay_ticks ticks (register at byte address 4, 0
// acts as 1); device write address at byte address 0. Configure only while idle.
module sccb_register_master
   import scrm_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_reg_addr,
   input  wire logic [7:0]  req_write_data,
   input  wire logic        req_sda_in,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_scl,
   output logic             rsp_sda_out,
   output logic             rsp_sda_drive,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_ack_ok,
   output logic             rsp_refused,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [7:0]                    device_addr_ff;
   logic [15:0]                   delay_ticks_ff;
   logic                          csr_write;
   item_type                      item;
   logic                          item_empty, item_pop;
   logic                          result_full, result_push;
   result_type                    result, rsp;
   logic [$bits(result_type)-1:0] rsp_bits;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_addr_ff <= DEVICE_ADDR_RESET;
         delay_ticks_ff <= DELAY_TICKS_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_DEVICE_ADDR) begin
            device_addr_ff <= csr_pwdata[7:0];
         end else begin
            delay_ticks_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_DELAY_TICKS) begin
         csr_prdata = {16'd0, delay_ticks_ff};
      end else begin
         csr_prdata = {24'd0, device_addr_ff};
      end
   end

   // front: take and classify ticks
   scrm_front #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .cmd        (req_cmd),
      .reg_addr   (req_reg_addr),
      .write_data (req_write_data),
      .sda_in     (req_sda_in),
      .pop        (item_pop),
      .item       (item),
      .empty      (item_empty)
   );

   // back: bit timing engine
   scrm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .device_addr (device_addr_ff),
      .delay_ticks (delay_ticks_ff),
      .item        (item),
      .item_empty  (item_empty),
      .item_pop    (item_pop),
      .result_full (result_full),
      .result_push (result_push),
      .result      (result)
   );

   // result queue
   scrm_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (QUEUE_DEPTH_P)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .full      (result_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   assign rsp           = result_type'(rsp_bits);
   assign rsp_scl       = rsp.scl;
   assign rsp_sda_out   = rsp.sda_out;
   assign rsp_sda_drive = rsp.sda_drive;
   assign rsp_busy_res  = rsp.busy;
   assign rsp_done_res  = rsp.done;
   assign rsp_read_data = rsp.read_data;
   assign rsp_ack_ok    = rsp.ack_ok;
   assign rsp_refused   = rsp.refused;

endmodule
`default_nettype wire
